[design/wbss_pkg.sv]
// Package for the wildcard byte signature scanner.
// Holds opcodes, field widths and default sizes; no dependencies.
package wbss_pkg;

  localparam int NUM_SIGS_DEF    = 16;
  localparam int MAX_PAT_LEN_DEF = 32;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 4;
  localparam int POS_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int SLEN_W  = 6;
  localparam int LIMIT_W = 17;
  localparam int MIDX_W  = 4;

  localparam logic [LIMIT_W-1:0] SCAN_CAP = 17'd65536;

  localparam logic [OP_W-1:0] OP_LOAD_PAT = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_LEN  = 2'd1;
  localparam logic [OP_W-1:0] OP_DATA     = 2'd2;
  localparam logic [OP_W-1:0] OP_END      = 2'd3;

endpackage

[design/wildcard_byte_signature_scan_top.sv]
// Wildcard byte signature scanner, top level.
// An end-of-buffer item is held in the input register; its result is then registered onto m_axis.
// Throughput: one item per cycle; an end item waits in the input register while output is full.
// Reset clears history, hit flags, byte count and lengths; scan_limit returns to 65536.
// Pattern bytes and care bits are not reset and read as garbage until written.
// Depends on wbss_pkg.
module wildcard_byte_signature_scan_top #(
  parameter int NUM_SIGS    = wbss_pkg::NUM_SIGS_DEF,
  parameter int MAX_PAT_LEN = wbss_pkg::MAX_PAT_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sig_slot[3:0], pattern_pos[8:4], byte_value[16:9], care[17], sig_length[23:18]
  input  logic [23:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // match_index[3:0], zero above
  output logic [7:0]  m_axis_tdata,
  // found[0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  localparam int LEN_W  = $clog2(MAX_PAT_LEN + 1);
  localparam int HIDX_W = $clog2(MAX_PAT_LEN);

  // input register
  logic                                 in_valid;
  logic [wbss_pkg::OP_W-1:0]            in_op;
  logic [wbss_pkg::SLOT_W-1:0]          in_slot;
  logic [wbss_pkg::POS_W-1:0]           in_pos;
  logic [wbss_pkg::BYTE_W-1:0]          in_byte;
  logic                                 in_care;
  logic [wbss_pkg::SLEN_W-1:0]          in_len;

  // state
  logic [wbss_pkg::LIMIT_W-1:0]         scan_limit;
  logic [7:0]                           history [MAX_PAT_LEN];
  logic [7:0]                           pattern_bytes [NUM_SIGS][MAX_PAT_LEN];
  logic                                 care_bits [NUM_SIGS][MAX_PAT_LEN];
  logic [LEN_W-1:0]                     lengths [NUM_SIGS];
  logic [wbss_pkg::LIMIT_W-1:0]         bytes_seen;
  logic [NUM_SIGS-1:0]                  hit_flags;

  // output register
  logic                                 out_valid;
  logic                                 out_found;
  logic [wbss_pkg::MIDX_W-1:0]          out_index;

  logic                                 out_free;
  logic                                 proc_fire;
  logic                                 scan_ok;
  logic                                 slot_ok;
  logic                                 pos_ok;
  logic [7:0]                           history_next [MAX_PAT_LEN];
  logic [wbss_pkg::LIMIT_W-1:0]         bytes_seen_next;
  logic [NUM_SIGS-1:0]                  sig_match;
  logic [LEN_W-1:0]                     tap;
  logic [LEN_W-1:0]                     len_clamped;
  logic                                 found_next;
  logic [wbss_pkg::MIDX_W-1:0]          index_next;
  logic [wbss_pkg::LIMIT_W-1:0]         cfg_capped;

  assign out_free      = !out_valid || m_axis_tready;
  assign proc_fire     = in_valid && ((in_op != wbss_pkg::OP_END) || out_free);
  assign s_axis_tready = !in_valid || proc_fire;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_found;
  assign m_axis_tdata  = {{(8 - wbss_pkg::MIDX_W){1'b0}}, out_index};

  assign scan_ok         = bytes_seen < scan_limit;
  assign bytes_seen_next = bytes_seen + 1'b1;
  assign slot_ok         = int'(in_slot) < NUM_SIGS;
  assign pos_ok          = int'(in_pos) < MAX_PAT_LEN;
  assign len_clamped     = (int'(in_len) > MAX_PAT_LEN) ? LEN_W'(MAX_PAT_LEN)
                                                        : LEN_W'(in_len);
  assign cfg_capped      = (cfg_data > wbss_pkg::SCAN_CAP) ? wbss_pkg::SCAN_CAP : cfg_data;

  // window compare: pattern byte j against the byte seen len-1-j bytes ago
  always_comb begin
    history_next[0] = in_byte;
    for (int i = 1; i < MAX_PAT_LEN; i++) begin
      history_next[i] = history[i-1];
    end
    tap = '0;
    for (int s = 0; s < NUM_SIGS; s++) begin
      sig_match[s] = (lengths[s] != '0) &&
                     (bytes_seen_next >= wbss_pkg::LIMIT_W'(lengths[s]));
      for (int j = 0; j < MAX_PAT_LEN; j++) begin
        tap = lengths[s] - LEN_W'(j + 1);
        if ((LEN_W'(j) < lengths[s]) && care_bits[s][j] &&
            (pattern_bytes[s][j] != history_next[tap[HIDX_W-1:0]])) begin
          sig_match[s] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    found_next = 1'b0;
    index_next = '0;
    for (int s = NUM_SIGS - 1; s >= 0; s--) begin
      if (hit_flags[s]) begin
        found_next = 1'b1;
        index_next = wbss_pkg::MIDX_W'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser;
      in_slot <= s_axis_tdata[3:0];
      in_pos  <= s_axis_tdata[8:4];
      in_byte <= s_axis_tdata[16:9];
      in_care <= s_axis_tdata[17];
      in_len  <= s_axis_tdata[23:18];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= wbss_pkg::SCAN_CAP;
    end else if (cfg_valid) begin
      scan_limit <= cfg_capped;
    end
  end

  // pattern store, not reset
  always_ff @(posedge clk) begin
    if (proc_fire && (in_op == wbss_pkg::OP_LOAD_PAT) && slot_ok && pos_ok) begin
      for (int s = 0; s < NUM_SIGS; s++) begin
        for (int j = 0; j < MAX_PAT_LEN; j++) begin
          if ((int'(in_slot) == s) && (int'(in_pos) == j)) begin
            pattern_bytes[s][j] <= in_byte;
            care_bits[s][j]     <= in_care;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SIGS; s++) begin
        lengths[s] <= '0;
      end
    end else if (proc_fire && (in_op == wbss_pkg::OP_SET_LEN) && slot_ok) begin
      for (int s = 0; s < NUM_SIGS; s++) begin
        if (int'(in_slot) == s) begin
          lengths[s] <= len_clamped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      hit_flags  <= '0;
      for (int i = 0; i < MAX_PAT_LEN; i++) begin
        history[i] <= '0;
      end
    end else if (proc_fire) begin
      if ((in_op == wbss_pkg::OP_DATA) && scan_ok) begin
        bytes_seen <= bytes_seen_next;
        hit_flags  <= hit_flags | sig_match;
        for (int i = 0; i < MAX_PAT_LEN; i++) begin
          history[i] <= history_next[i];
        end
      end else if (in_op == wbss_pkg::OP_END) begin
        bytes_seen <= '0;
        hit_flags  <= '0;
        for (int i = 0; i < MAX_PAT_LEN; i++) begin
          history[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && (in_op == wbss_pkg::OP_END)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && (in_op == wbss_pkg::OP_END)) begin
      out_found <= found_next;
      out_index <= index_next;
    end
  end

endmodule
